// File: sv/gpiorb_pkg.sv
// Package for the GPIO register block: function codes, register offsets,
// stream field widths and the struct handed to the input sampler.
// No dependencies.
`default_nettype none

package gpiorb_pkg;

  localparam int unsigned WordW = 32;

  // item kinds carried on s_tuser
  typedef enum logic [2:0] {
    FUNC_READ     = 3'd0,
    FUNC_WRITE    = 3'd1,
    FUNC_PIN      = 3'd2,
    FUNC_BE_MASK  = 3'd3,
    FUNC_BE_LEVEL = 3'd4
  } func_t;

  // register word offsets
  localparam logic [4:0] RegIntrState  = 5'd0;
  localparam logic [4:0] RegIntrEnable = 5'd1;
  localparam logic [4:0] RegIntrTest   = 5'd2;
  localparam logic [4:0] RegAlertTest  = 5'd3;
  localparam logic [4:0] RegDataIn     = 5'd4;
  localparam logic [4:0] RegDirectOut  = 5'd5;
  localparam logic [4:0] RegMaskOutLo  = 5'd6;
  localparam logic [4:0] RegMaskOutHi  = 5'd7;
  localparam logic [4:0] RegDirectOe   = 5'd8;
  localparam logic [4:0] RegMaskOeLo   = 5'd9;
  localparam logic [4:0] RegMaskOeHi   = 5'd10;
  localparam logic [4:0] RegRiseEn     = 5'd11;
  localparam logic [4:0] RegFallEn     = 5'd12;
  localparam logic [4:0] RegHighEn     = 5'd13;
  localparam logic [4:0] RegLowEn      = 5'd14;
  localparam logic [4:0] RegFilterEn   = 5'd15;

  // configuration register indexes
  localparam logic [1:0] CfgInvert    = 2'd0;
  localparam logic [1:0] CfgOpenDrain = 2'd1;
  localparam logic [1:0] CfgPullEn    = 2'd2;
  localparam logic [1:0] CfgPullUp    = 2'd3;

  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 136;

  localparam logic [WordW-1:0] HalfHi = 32'hFFFF_0000;

  // everything the sampler looks at; prev_sample and pending are from before the beat, the rest after it
  typedef struct packed {
    logic [WordW-1:0] prev_sample;
    logic [WordW-1:0] pending;
    logic [WordW-1:0] out_val;
    logic [WordW-1:0] out_en;
    logic [WordW-1:0] line_lvl;
    logic [WordW-1:0] line_rel;
    logic [WordW-1:0] line_conn;
    logic [WordW-1:0] be_lvl;
    logic [WordW-1:0] be_ign;
    logic [WordW-1:0] rise_en;
    logic [WordW-1:0] fall_en;
    logic [WordW-1:0] high_en;
    logic [WordW-1:0] low_en;
    logic [WordW-1:0] invert;
    logic [WordW-1:0] pull_en;
    logic [WordW-1:0] pull_up;
  } samp_in_t;

  typedef struct packed {
    logic [WordW-1:0] sample;
    logic [WordW-1:0] pending;
  } samp_out_t;

endpackage

`default_nettype wire

// File: sv/gpiorb_sampler.sv
// Input sampler: picks line, backend or pull level per pin, applies inversion
// and loopback, and folds edge and level conditions into the pending bits.
// Depends on gpiorb_pkg.
`default_nettype none

module gpiorb_sampler #(
  parameter int unsigned PIN_COUNT = 32
) (
  input  wire gpiorb_pkg::samp_in_t si,
  output gpiorb_pkg::samp_out_t     so
);
  import gpiorb_pkg::*;

  localparam logic [WordW-1:0] PinMask = 32'hFFFF_FFFF >> (WordW - PIN_COUNT);

  logic [WordW-1:0] not_oe;
  logic [WordW-1:0] line_sel;
  logic [WordW-1:0] back_sel;
  logic [WordW-1:0] pull_pick;
  logic [WordW-1:0] raw;
  logic [WordW-1:0] smp;
  logic [WordW-1:0] change;

  always_comb begin
    not_oe    = ~si.out_en;
    line_sel  = si.line_conn & ~si.line_rel & not_oe;
    back_sel  = ~si.line_conn & ~si.be_ign & not_oe;
    pull_pick = si.line_conn & si.line_rel & si.be_ign & not_oe;
    raw       = (si.line_lvl & line_sel) | (si.be_lvl & back_sel) |
                (si.pull_en & si.pull_up & pull_pick);
    // driven outputs loop back after inversion
    smp       = ((raw ^ si.invert) | (si.out_val & si.out_en)) & PinMask;
    change    = si.prev_sample ^ smp;
    so.sample  = smp;
    so.pending = (si.pending | (si.low_en & ~smp) | (si.high_en & smp) |
                  (si.rise_en & change & smp) | (si.fall_en & change & ~smp)) & PinMask;
  end

endmodule

`default_nettype wire

// File: sv/gpio_register_block_with_pin_irqs_core.sv
// GPIO register block top level: stream in/out, configuration port, pin state
// registers, bus register decode and the output register.
// Depends on gpiorb_pkg and gpiorb_sampler.
//
//   channel | dir | handshake              | payload
//   s       | in  | s_tvalid / s_tready    | s_tuser func, s_tdata rest of item
//   m       | out | m_tvalid / m_tready    | m_tdata result
//   cfg     | in  | cfg_we                 | cfg_index, cfg_data
//
// One item per cycle unless the result register is held: every beat is decoded,
// applied to the pin state and registered into the result stage in the cycle it is
// accepted. The single result register holds a beat while m_tready is low;
// s_tready stays high as long as that register is empty or being drained.
// rst is synchronous and clears pin state, configuration and m_tvalid to zero; m_tdata is not reset.
`default_nettype none

module gpio_register_block_with_pin_irqs_core #(
  parameter int unsigned PIN_COUNT = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // [4:0] reg_index, [36:5] write_data, [41:37] pin_index, [42] pin_level,
  // [43] pin_release, [75:44] backend_word, [79:76] zero
  input  wire logic [gpiorb_pkg::InDataW-1:0] s_tdata,
  // [2:0] func
  input  wire logic [2:0]                     s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // [31:0] read_data, [63:32] irq_lines, [95:64] pad_drive_value,
  // [127:96] pad_drive_enable, [128] alert_out, [135:129] zero
  output logic [gpiorb_pkg::OutDataW-1:0]     m_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [gpiorb_pkg::WordW-1:0]   cfg_data
);
  import gpiorb_pkg::*;

  localparam logic [WordW-1:0] PinMask = 32'hFFFF_FFFF >> (WordW - PIN_COUNT);
  localparam logic [5:0]       PinLim  = 6'(PIN_COUNT);

  // configuration
  logic [WordW-1:0] invert_mask, open_drain_mask, pull_enable_mask, pull_up_mask;

  // pin state
  logic [WordW-1:0] irq_pending, irq_enable, sampled_input;
  logic [WordW-1:0] output_value, output_enable;
  logic [WordW-1:0] rise_en, fall_en, high_en, low_en, filter_enable;
  logic [WordW-1:0] line_level, line_released, line_connected;
  logic [WordW-1:0] backend_level, backend_ignore;
  logic             alert_level;

  logic [WordW-1:0] irq_pending_next, irq_enable_next, sampled_input_next;
  logic [WordW-1:0] output_value_next, output_enable_next;
  logic [WordW-1:0] rise_en_next, fall_en_next, high_en_next, low_en_next;
  logic [WordW-1:0] filter_enable_next;
  logic [WordW-1:0] line_level_next, line_released_next, line_connected_next;
  logic [WordW-1:0] backend_level_next, backend_ignore_next;
  logic             alert_level_next;

  // pending bits after bus writes, before any resample
  logic [WordW-1:0] irq_pending_wr;

  // unpacked item
  logic [2:0]       func;
  logic [4:0]       reg_index;
  logic [WordW-1:0] write_data;
  logic [4:0]       pin_index;
  logic             pin_level;
  logic             pin_release;
  logic [WordW-1:0] backend_word;

  logic             accept;
  logic             resample;
  logic [WordW-1:0] wd_pin;
  logic [WordW-1:0] pin_bit;
  logic [WordW-1:0] m_lo, m_hi;
  logic [WordW-1:0] read_data;
  logic [WordW-1:0] pad_val, pad_oen;
  samp_in_t         si;
  samp_out_t        so;

  assign func         = s_tuser;
  assign reg_index    = s_tdata[4:0];
  assign write_data   = s_tdata[36:5];
  assign pin_index    = s_tdata[41:37];
  assign pin_level    = s_tdata[42];
  assign pin_release  = s_tdata[43];
  assign backend_word = s_tdata[75:44];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // bus read decode, from state before the beat
  always_comb begin
    unique case (reg_index)
      RegIntrState:  read_data = irq_pending;
      RegIntrEnable: read_data = irq_enable;
      RegDataIn:     read_data = sampled_input;
      RegDirectOut:  read_data = output_value;
      RegMaskOutLo:  read_data = {16'd0, output_value[15:0]};
      RegMaskOutHi:  read_data = {16'd0, output_value[31:16]};
      RegDirectOe:   read_data = output_enable;
      RegMaskOeLo:   read_data = {16'd0, output_enable[15:0]};
      RegMaskOeHi:   read_data = {16'd0, output_enable[31:16]};
      RegRiseEn:     read_data = rise_en;
      RegFallEn:     read_data = fall_en;
      RegHighEn:     read_data = high_en;
      RegLowEn:      read_data = low_en;
      RegFilterEn:   read_data = filter_enable;
      default:       read_data = '0;
    endcase
  end

  // apply the beat to the state
  always_comb begin
    irq_pending_wr      = irq_pending;
    irq_enable_next     = irq_enable;
    output_value_next   = output_value;
    output_enable_next  = output_enable;
    rise_en_next        = rise_en;
    fall_en_next        = fall_en;
    high_en_next        = high_en;
    low_en_next         = low_en;
    filter_enable_next  = filter_enable;
    line_level_next     = line_level;
    line_released_next  = line_released;
    line_connected_next = line_connected;
    backend_level_next  = backend_level;
    backend_ignore_next = backend_ignore;
    alert_level_next    = alert_level;
    resample            = 1'b0;

    wd_pin  = write_data & PinMask;
    pin_bit = WordW'(1) << pin_index;
    // masked halves: upper 16 bits of the word select, lower 16 bits carry data
    m_lo    = {16'd0, write_data[31:16]};
    m_hi    = write_data & HalfHi;

    case (func)
      FUNC_WRITE: begin
        unique case (reg_index)
          RegIntrState:  irq_pending_wr = irq_pending & ~write_data;
          RegIntrEnable: irq_enable_next = wd_pin;
          RegIntrTest:   irq_pending_wr = irq_pending | wd_pin;
          RegAlertTest:  alert_level_next = write_data[0];
          RegDirectOut: begin
            output_value_next = wd_pin;
            resample = 1'b1;
          end
          RegMaskOutLo: begin
            output_value_next = ((output_value & ~m_lo) | (write_data & m_lo)) & PinMask;
            resample = 1'b1;
          end
          RegMaskOutHi: begin
            output_value_next = ((output_value & ~m_hi) | ((write_data << 16) & m_hi))
                                & PinMask;
            resample = 1'b1;
          end
          RegDirectOe: begin
            output_enable_next = wd_pin;
            resample = 1'b1;
          end
          RegMaskOeLo: begin
            output_enable_next = ((output_enable & ~m_lo) | (write_data & m_lo)) & PinMask;
            resample = 1'b1;
          end
          RegMaskOeHi: begin
            output_enable_next = ((output_enable & ~m_hi) | ((write_data << 16) & m_hi))
                                 & PinMask;
            resample = 1'b1;
          end
          RegRiseEn:     rise_en_next = wd_pin;
          RegFallEn:     fall_en_next = wd_pin;
          RegHighEn: begin
            high_en_next = wd_pin;
            resample = 1'b1;
          end
          RegLowEn: begin
            low_en_next = wd_pin;
            resample = 1'b1;
          end
          RegFilterEn:   filter_enable_next = wd_pin;
          default: ;
        endcase
      end
      FUNC_PIN: begin
        // drop events for pins beyond the configured count
        if ({1'b0, pin_index} < PinLim) begin
          line_connected_next = line_connected | pin_bit;
          if (pin_release) begin
            line_released_next = line_released | pin_bit;
          end else begin
            line_level_next    = pin_level ? (line_level | pin_bit) : (line_level & ~pin_bit);
            line_released_next = line_released & ~pin_bit;
          end
          resample = 1'b1;
        end
      end
      FUNC_BE_MASK: begin
        backend_ignore_next = backend_word & PinMask;
        resample = 1'b1;
      end
      FUNC_BE_LEVEL: begin
        backend_level_next = backend_word & PinMask;
        resample = 1'b1;
      end
      default: ;
    endcase
  end

  // take the new sample and pending bits when the beat resamples
  always_comb begin
    sampled_input_next = sampled_input;
    irq_pending_next   = irq_pending_wr;
    if (resample) begin
      sampled_input_next = so.sample;
      irq_pending_next   = so.pending;
    end
  end

  always_comb begin
    si.prev_sample = sampled_input;
    si.pending     = irq_pending;
    si.out_val     = output_value_next;
    si.out_en      = output_enable_next;
    si.line_lvl    = line_level_next;
    si.line_rel    = line_released_next;
    si.line_conn   = line_connected_next;
    si.be_lvl      = backend_level_next;
    si.be_ign      = backend_ignore_next;
    si.rise_en     = rise_en_next;
    si.fall_en     = fall_en_next;
    si.high_en     = high_en_next;
    si.low_en      = low_en_next;
    si.invert      = invert_mask;
    si.pull_en     = pull_enable_mask;
    si.pull_up     = pull_up_mask;
  end

  gpiorb_sampler #(
    .PIN_COUNT(PIN_COUNT)
  ) u_sampler (
    .si(si),
    .so(so)
  );

  // pad drive after the beat; open-drain pins release when driving high
  always_comb begin
    pad_oen = output_enable_next &
              ~(open_drain_mask & (output_value_next ^ invert_mask)) & PinMask;
    pad_val = (output_value_next ^ invert_mask) & pad_oen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      invert_mask      <= '0;
      open_drain_mask  <= '0;
      pull_enable_mask <= '0;
      pull_up_mask     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgInvert:    invert_mask      <= cfg_data & PinMask;
        CfgOpenDrain: open_drain_mask  <= cfg_data & PinMask;
        CfgPullEn:    pull_enable_mask <= cfg_data & PinMask;
        CfgPullUp:    pull_up_mask     <= cfg_data & PinMask;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      irq_pending    <= '0;
      irq_enable     <= '0;
      sampled_input  <= '0;
      output_value   <= '0;
      output_enable  <= '0;
      rise_en        <= '0;
      fall_en        <= '0;
      high_en        <= '0;
      low_en         <= '0;
      filter_enable  <= '0;
      line_level     <= '0;
      line_released  <= '0;
      line_connected <= '0;
      backend_level  <= '0;
      backend_ignore <= '0;
      alert_level    <= 1'b0;
    end else if (accept) begin
      irq_pending    <= irq_pending_next;
      irq_enable     <= irq_enable_next;
      sampled_input  <= sampled_input_next;
      output_value   <= output_value_next;
      output_enable  <= output_enable_next;
      rise_en        <= rise_en_next;
      fall_en        <= fall_en_next;
      high_en        <= high_en_next;
      low_en         <= low_en_next;
      filter_enable  <= filter_enable_next;
      line_level     <= line_level_next;
      line_released  <= line_released_next;
      line_connected <= line_connected_next;
      backend_level  <= backend_level_next;
      backend_ignore <= backend_ignore_next;
      alert_level    <= alert_level_next;
    end
  end

  // result stage: hold the beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {7'd0,
                  alert_level_next,
                  pad_oen,
                  pad_val,
                  irq_pending_next & irq_enable_next,
                  (func == FUNC_READ) ? read_data : {WordW{1'b0}}};
    end
  end

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for the 32-pin GPIO register block: stream items in, one result per item.
// It runs a directed table and then random phases; each result is checked against a predictor or a fixed row value.
// Depends on gpiorb_pkg and gpio_register_block_with_pin_irqs_core.
`timescale 1ns / 100ps

module testbench;
  import gpiorb_pkg::*;

  localparam int unsigned PhaseCount = 6;
  localparam int unsigned PhaseItems = 150;
  localparam int unsigned HoldCycles = 96;
  localparam int unsigned HoldAfter  = 250;
  localparam int unsigned ShowLimit  = 10;
  localparam logic [2:0]  FuncUnused = 3'd7;
  localparam logic [2:0]  FuncFirstUnknown = 3'd5;

  typedef struct packed {
    logic [31:0] read_data;
    logic [31:0] irq_lines;
    logic [31:0] pad_value;
    logic [31:0] pad_enable;
    logic        alert;
  } gpio_result_t;

  typedef struct {
    logic [2:0]         f;
    logic [InDataW-1:0] d;
    logic               fixed;
    gpio_result_t       want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [InDataW-1:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [WordW-1:0] cfg_data = '0;

  // beat tag: a typed expectation that travels with the item on the bus
  logic tag_fixed = 1'b0;
  gpio_result_t tag_want = '0;

  int unsigned tx_idle_pct = 20;
  int unsigned rx_idle_pct = 50;

  gpio_result_t expect_q[$];
  int unsigned faults = 0;
  int unsigned beats_in = 0;
  int unsigned results_seen = 0;
  int unsigned settings_done = 0;

  // predictor state
  logic [31:0] cfg_inv = '0, cfg_od = '0, cfg_pen = '0, cfg_pup = '0;
  logic [31:0] pend = '0, irq_en = '0, samp = '0, out_val = '0, out_en = '0;
  logic [31:0] rise_en = '0, fall_en = '0, hi_en = '0, lo_en = '0, filt_en = '0;
  logic [31:0] ln_lvl = '0, ln_rel = '0, ln_conn = '0, be_lvl = '0, be_ign = '0;
  logic        alert = 1'b0;

  gpio_register_block_with_pin_irqs_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // resolve each pin from line, backend or pull, then raise level and edge interrupts
  task automatic refresh_input();
    logic [31:0] prev, free, v, chg;
    prev = samp;
    free = ~out_en;
    v = (ln_lvl & ln_conn & ~ln_rel & free) |
        (be_lvl & ~ln_conn & ~be_ign & free) |
        (cfg_pen & cfg_pup & ln_conn & ln_rel & be_ign & free);
    v = (v ^ cfg_inv) | (out_val & out_en);
    samp = v;
    chg = prev ^ v;
    pend |= (lo_en & ~v) | (hi_en & v) | (rise_en & chg & v) | (fall_en & chg & ~v);
  endtask

  function automatic logic [31:0] reg_value(input logic [4:0] ri);
    case (ri)
      RegIntrState:  return pend;
      RegIntrEnable: return irq_en;
      RegDataIn:     return samp;
      RegDirectOut:  return out_val;
      RegMaskOutLo:  return {16'h0, out_val[15:0]};
      RegMaskOutHi:  return {16'h0, out_val[31:16]};
      RegDirectOe:   return out_en;
      RegMaskOeLo:   return {16'h0, out_en[15:0]};
      RegMaskOeHi:   return {16'h0, out_en[31:16]};
      RegRiseEn:     return rise_en;
      RegFallEn:     return fall_en;
      RegHighEn:     return hi_en;
      RegLowEn:      return lo_en;
      RegFilterEn:   return filt_en;
      default:       return '0;
    endcase
  endfunction

  // masked halves: the upper 16 bits of the word select, the lower 16 carry data
  function automatic logic [31:0] merge_lo(input logic [31:0] old, input logic [31:0] w);
    logic [31:0] m;
    m = w >> 16;
    return (old & ~m) | (w & m);
  endfunction

  function automatic logic [31:0] merge_hi(input logic [31:0] old, input logic [31:0] w);
    logic [31:0] m;
    m = w & HalfHi;
    return (old & ~m) | ((w << 16) & m);
  endfunction

  task automatic reg_write(input logic [4:0] ri, input logic [31:0] w);
    case (ri)
      RegIntrState:  pend &= ~w;
      RegIntrEnable: irq_en = w;
      RegIntrTest:   pend |= w;
      RegAlertTest:  alert = w[0];
      RegDirectOut:  begin out_val = w; refresh_input(); end
      RegMaskOutLo:  begin out_val = merge_lo(out_val, w); refresh_input(); end
      RegMaskOutHi:  begin out_val = merge_hi(out_val, w); refresh_input(); end
      RegDirectOe:   begin out_en = w; refresh_input(); end
      RegMaskOeLo:   begin out_en = merge_lo(out_en, w); refresh_input(); end
      RegMaskOeHi:   begin out_en = merge_hi(out_en, w); refresh_input(); end
      RegRiseEn:     rise_en = w;
      RegFallEn:     fall_en = w;
      RegHighEn:     begin hi_en = w; refresh_input(); end
      RegLowEn:      begin lo_en = w; refresh_input(); end
      RegFilterEn:   filt_en = w;
      default: ;
    endcase
  endtask

  task automatic gpio_step(input logic [2:0] f, input logic [InDataW-1:0] d,
                           output gpio_result_t r);
    logic [4:0] pin;
    logic [31:0] drv;
    pin = d[41:37];
    r = '0;
    case (f)
      FUNC_READ:  r.read_data = reg_value(d[4:0]);
      FUNC_WRITE: reg_write(d[4:0], d[36:5]);
      FUNC_PIN: begin
        ln_conn[pin] = 1'b1;
        if (d[43]) begin
          ln_rel[pin] = 1'b1;
        end else begin
          ln_lvl[pin] = d[42];
          ln_rel[pin] = 1'b0;
        end
        refresh_input();
      end
      FUNC_BE_MASK:  begin be_ign = d[75:44]; refresh_input(); end
      FUNC_BE_LEVEL: begin be_lvl = d[75:44]; refresh_input(); end
      default: ;
    endcase
    drv = out_val ^ cfg_inv;
    // open-drain pins release the pad when they would drive high
    r.pad_enable = out_en & ~(cfg_od & drv);
    r.pad_value = drv & r.pad_enable;
    r.irq_lines = pend & irq_en;
    r.alert = alert;
  endtask

  task automatic note_field(input string fname, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      faults++;
      if (faults <= ShowLimit)
        $display("mismatch in %s of result %0d: expected %h, got %h",
                 fname, results_seen, want, got);
    end
  endtask

  always @(posedge clk) begin : scoreboard
    gpio_result_t r;
    gpio_result_t got;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_index)
          CfgInvert:    cfg_inv = cfg_data;
          CfgOpenDrain: cfg_od = cfg_data;
          CfgPullEn:    cfg_pen = cfg_data;
          CfgPullUp:    cfg_pup = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        gpio_step(s_tuser, s_tdata, r);
        expect_q.push_back(tag_fixed ? tag_want : r);
        beats_in++;
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        got.read_data = m_tdata[31:0];
        got.irq_lines = m_tdata[63:32];
        got.pad_value = m_tdata[95:64];
        got.pad_enable = m_tdata[127:96];
        got.alert = m_tdata[128];
        if (expect_q.size() == 0) begin
          faults++;
          if (faults <= ShowLimit) $display("result %0d arrived with nothing pending", results_seen);
        end else begin
          r = expect_q.pop_front();
          note_field("read_data", r.read_data, got.read_data);
          note_field("irq_lines", r.irq_lines, got.irq_lines);
          note_field("pad_drive_value", r.pad_value, got.pad_value);
          note_field("pad_drive_enable", r.pad_enable, got.pad_enable);
          note_field("alert_out", {31'h0, r.alert}, {31'h0, got.alert});
        end
      end
    end
  end

  // result side: random stalls, plus one long hold-off that backs up the input
  initial begin : result_side
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && beats_in >= HoldAfter) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    #400000;
    $display("watchdog expired with %0d results outstanding", expect_q.size());
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    dir_row_t dir_rows[$];
    int unsigned p, n, k, wait_n, dir_count;
    logic [31:0] v;
    logic [2:0] f;
    logic [4:0] ri;
    int unsigned pick;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    dir_add(FUNC_READ, RegIntrState, '0, '0, 1'b0, 1'b0, '0);
    dir_fix('0, '0, '0, '0, 1'b0);
    dir_add(FUNC_READ, 5'd31, '0, '0, 1'b0, 1'b0, '0);
    dir_fix('0, '0, '0, '0, 1'b0);
    dir_add(FUNC_WRITE, RegAlertTest, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0);
    dir_fix('0, '0, '0, '0, 1'b1);
    dir_add(FUNC_READ, RegAlertTest, '0, '0, 1'b0, 1'b0, '0);
    dir_fix('0, '0, '0, '0, 1'b1);
    dir_add(FUNC_WRITE, RegAlertTest, 32'hFFFF_FFFE, '0, 1'b0, 1'b0, '0);
    dir_fix('0, '0, '0, '0, 1'b0);
    dir_add(FUNC_WRITE, RegDirectOut, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0);
    dir_fix('0, '0, '0, '0, 1'b0);
    dir_add(FUNC_READ, RegDirectOut, '0, '0, 1'b0, 1'b0, '0);
    dir_fix(32'hFFFF_FFFF, '0, '0, '0, 1'b0);
    dir_add(FUNC_WRITE, RegDirectOe, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0);
    dir_fix('0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    dir_add(FUNC_WRITE, RegMaskOutLo, 32'hFFFF_0000, '0, 1'b0, 1'b0, '0);
    dir_add(FUNC_WRITE, RegMaskOutHi, 32'h8001_0001, '0, 1'b0, 1'b0, '0);
    dir_add(FUNC_WRITE, RegMaskOeLo, 32'h00FF_0000, '0, 1'b0, 1'b0, '0);
    dir_add(FUNC_WRITE, RegMaskOeHi, 32'hFFFF_0000, '0, 1'b0, 1'b0, '0);
    dir_add(FUNC_READ, RegMaskOeLo, '0, '0, 1'b0, 1'b0, '0);
    dir_add(FUNC_WRITE, RegIntrEnable, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0);
    dir_add(FUNC_WRITE, RegIntrTest, 32'h0000_00F0, '0, 1'b0, 1'b0, '0);
    dir_add(FUNC_WRITE, RegIntrState, 32'h0000_0030, '0, 1'b0, 1'b0, '0);
    dir_add(FUNC_WRITE, RegRiseEn, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0);
    dir_add(FUNC_WRITE, RegFallEn, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0);
    dir_add(FUNC_PIN, '0, '0, 5'd31, 1'b1, 1'b0, '0);
    dir_add(FUNC_PIN, '0, '0, 5'd0, 1'b0, 1'b1, '0);
    dir_add(FUNC_BE_MASK, '0, '0, '0, 1'b0, 1'b0, 32'hFFFF_FFFF);
    dir_add(FUNC_BE_LEVEL, '0, '0, '0, 1'b0, 1'b0, 32'hA5A5_A5A5);
    dir_add(FUNC_WRITE, RegLowEn, 32'h0000_FFFF, '0, 1'b0, 1'b0, '0);
    dir_add(FUNC_WRITE, RegDataIn, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0);
    dir_add(FUNC_READ, RegDataIn, '0, '0, 1'b0, 1'b0, '0);
    dir_add(FuncUnused, RegIntrState, 32'hFFFF_FFFF, 5'd31, 1'b1, 1'b1, 32'hFFFF_FFFF);
    dir_add(FUNC_WRITE, 5'd16, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0);

    dir_count = dir_rows.size();
    foreach (dir_rows[i])
      offer(dir_rows[i].f, dir_rows[i].d, dir_rows[i].fixed, dir_rows[i].want);

    for (p = 0; p < PhaseCount; p++) begin
      // first two phases: sender idles lightly, receiver heavily; then swapped; then none
      tx_idle_pct = (p < 2) ? 20 : (p < 4) ? 50 : 0;
      rx_idle_pct = (p < 2) ? 50 : (p < 4) ? 20 : 0;
      settle();
      // register index equals its position in the list
      for (k = 0; k < 4; k++) begin
        case (p)
          1: v = '1;
          2: v = '0;
          3: v = (k % 2 == 0) ? '1 : '0;
          default: v = $urandom();
        endcase
        cfg_we <= 1'b1;
        cfg_index <= k[1:0];
        cfg_data <= v;
        @(posedge clk);
      end
      cfg_we <= 1'b0;
      settings_done++;

      for (n = 0; n < PhaseItems; n++) begin
        pick = $urandom_range(99);
        if (pick < 28) f = FUNC_READ;
        else if (pick < 60) f = FUNC_WRITE;
        else if (pick < 82) f = FUNC_PIN;
        else if (pick < 88) f = FUNC_BE_MASK;
        else if (pick < 95) f = FUNC_BE_LEVEL;
        else f = 3'($urandom_range(FuncUnused, FuncFirstUnknown));
        ri = ($urandom_range(99) < 90) ? 5'($urandom_range(RegFilterEn)) : 5'($urandom_range(31, 16));
        offer(f, pack_item(ri, $urandom(), 5'($urandom_range(31)), 1'($urandom_range(1)),
                           1'($urandom_range(1)), $urandom()), 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    for (wait_n = 0; expect_q.size() != 0 && wait_n < 2000; wait_n++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (expect_q.size() != 0) begin
      faults += expect_q.size();
      $display("%0d results never arrived", expect_q.size());
    end

    $display("covered %0d items (%0d directed rows) and %0d results over %0d register settings",
             beats_in, dir_count, results_seen, settings_done);
    $display("reads, masked writes, pin and backend events, one %0d-cycle output stall",
             HoldCycles);
    if (faults == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d failures", faults);
      $display("status: fail");
    end
    $finish;
  end

  function automatic logic [InDataW-1:0] pack_item(input logic [4:0] ri, input logic [31:0] w,
      input logic [4:0] pin, input logic lvl, input logic rel, input logic [31:0] bw);
    return {4'h0, bw, rel, lvl, pin, w, ri};
  endfunction

  task automatic dir_add(input logic [2:0] f, input logic [4:0] ri, input logic [31:0] w,
      input logic [4:0] pin, input logic lvl, input logic rel, input logic [31:0] bw);
    dir_row_t row;
    row.f = f;
    row.d = pack_item(ri, w, pin, lvl, rel, bw);
    row.fixed = 1'b0;
    row.want = '0;
    stimulus.dir_rows.push_back(row);
  endtask

  task automatic dir_fix(input logic [31:0] rd, input logic [31:0] irq, input logic [31:0] pv,
      input logic [31:0] pe, input logic al);
    int unsigned last;
    last = stimulus.dir_rows.size() - 1;
    stimulus.dir_rows[last].fixed = 1'b1;
    stimulus.dir_rows[last].want = '{rd, irq, pv, pe, al};
  endtask

  // present one beat and hold it until accepted; random gaps go in front
  task automatic offer(input logic [2:0] f, input logic [InDataW-1:0] d, input logic fixed,
      input gpio_result_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= d;
    tag_fixed <= fixed;
    tag_want <= want;
    do @(posedge clk); while (!s_tready);
  endtask

  // drop valid and wait until every pending result has come out
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expect_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

endmodule

// File: files.f
sv/gpiorb_pkg.sv
sv/gpiorb_sampler.sv
sv/gpio_register_block_with_pin_irqs_core.sv
bench/testbench.sv
